>>> src/assert_macros.svh
// Assertion macros shared by checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("check failed");
`endif

>>> src/stm_pkg.sv
// Package for the session table: sizes, codes, state type.
// No dependencies.
`default_nettype none
package stm_pkg;
    localparam int BUCKETS = 4;
    localparam int SLOTS_PER_BUCKET = 16;
    localparam int BW = $clog2(BUCKETS) > 0 ? $clog2(BUCKETS) : 1;
    localparam int SW = $clog2(SLOTS_PER_BUCKET);
    localparam int FW = SW + 1;
    localparam int AW = BW + SW;
    localparam int DEPTH = BUCKETS * SLOTS_PER_BUCKET;
    localparam logic [15:0] AGE_LIMIT_RST = 16'd40;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_SWEEP  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // one stored session: user, client, server ip, client ip, ports, age
    typedef struct packed {
        logic [31:0] user;
        logic [31:0] client;
        logic [31:0] server_ip;
        logic [31:0] client_ip;
        logic [15:0] server_port;
        logic [15:0] client_port;
        logic [15:0] age;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_TAIL, S_NEXTB, S_DONE
    } t_state;
endpackage
`default_nettype wire

>>> src/stm_if.sv
// Request and result channel interfaces.
// Depends on nothing.
`default_nettype none
interface stm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  bucket;
    logic [31:0] user_id;
    logic [31:0] client_id;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    modport source (output valid, command, bucket, user_id, client_id, server_ip,
                    server_port, client_ip, client_port, input ready);
    modport sink (input valid, command, bucket, user_id, client_id, server_ip,
                  server_port, client_ip, client_port, output ready);
endinterface

interface stm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_client_ip;
    logic [15:0] found_client_port;
    modport source (output valid, status, found_client_ip, found_client_port,
                    input ready);
    modport sink (input valid, status, found_client_ip, found_client_port,
                  output ready);
endinterface
`default_nettype wire

>>> src/session_table_match_and_age.sv
// Bucketed session table with aging; top level.
// Depends on stm_pkg, stm_if, stm_slot_ram.
//
// Usage: requests enter on i_req (valid/ready); one result leaves on o_res.
// Insert appends a session to its bucket (status full if no room). Lookup
// walks the bucket oldest first: passed entries age by one or drop out once
// their age exceeds age_limit; the first match on user, client id, server
// address and port returns client address/port and is removed. Sweep ages all
// buckets. Entries are compacted in place through one slot memory.
// Insert and the unused command go through the NEXTB state to the result.
// Lookup and sweep walk the slots through a READ and an EVAL state per slot
// (registered read, then write back). One request is worked at a time;
// ready is low from acceptance until its result is taken. A stalled
// receiver holds the result and blocks the next request. Reset (synchronous,
// active low) empties all buckets and loads age_limit with 40; no memory
// clearing is needed. i_cfg_we writes age_limit; the user must do so only
// while idle, which the block does not enforce.
`default_nettype none
module session_table_match_and_age (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_wdata,
    stm_req_if.sink    i_req,
    stm_res_if.source  o_res
);
    stm_pkg::t_state r_state, n_state;
    logic [stm_pkg::FW-1:0] r_fill [stm_pkg::BUCKETS];
    logic [15:0] r_limit;
    logic [1:0]  r_cmd;
    logic [stm_pkg::BW-1:0] r_b;
    logic [31:0] r_user, r_client, r_sip, r_cip;
    logic [15:0] r_sport, r_cport;
    logic [stm_pkg::FW-1:0] r_rd, r_wr;
    logic        r_hit;
    logic [1:0]  r_status;
    logic [31:0] r_fip;
    logic [15:0] r_fport;

    logic we;
    logic [stm_pkg::AW-1:0] waddr, raddr;
    stm_pkg::t_slot wdata, rdata, aged;
    logic [stm_pkg::FW-1:0] fill_b;
    logic match, keep;

    stm_slot_ram u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign fill_b = r_fill[r_b];
    assign raddr = {r_b, r_rd[stm_pkg::SW-1:0]};
    assign match = (r_cmd == stm_pkg::CMD_LOOKUP) && !r_hit && rdata.user == r_user
        && rdata.client == r_client && rdata.server_ip == r_sip
        && rdata.server_port == r_sport;
    assign keep = r_hit || rdata.age <= r_limit;
    always_comb begin
        aged = rdata;
        if (!r_hit && rdata.age != stm_pkg::AGE_MAX) begin
            aged.age = rdata.age + 16'd1;
        end
    end

    assign i_req.ready = (r_state == stm_pkg::S_IDLE);
    assign o_res.valid = (r_state == stm_pkg::S_DONE);
    assign o_res.status = r_status;
    assign o_res.found_client_ip = r_fip;
    assign o_res.found_client_port = r_fport;

    always_comb begin
        n_state = r_state;
        we = 1'b0;
        waddr = {r_b, r_wr[stm_pkg::SW-1:0]};
        wdata = aged;
        case (r_state)
            stm_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = stm_pkg::S_NEXTB;
                end
            end
            stm_pkg::S_NEXTB: begin
                if (r_cmd == stm_pkg::CMD_INSERT) begin
                    if (fill_b < stm_pkg::FW'(stm_pkg::SLOTS_PER_BUCKET)) begin
                        we = 1'b1;
                        waddr = {r_b, fill_b[stm_pkg::SW-1:0]};
                        wdata = '{r_user, r_client, r_sip, r_cip, r_sport, r_cport,
                                  16'd0};
                    end
                    n_state = stm_pkg::S_DONE;
                end else if (r_cmd != stm_pkg::CMD_LOOKUP
                             && r_cmd != stm_pkg::CMD_SWEEP) begin
                    n_state = stm_pkg::S_DONE;
                end else begin
                    n_state = stm_pkg::S_READ;
                end
            end
            stm_pkg::S_READ: begin
                if (r_rd >= fill_b) begin
                    n_state = stm_pkg::S_TAIL;
                end else begin
                    n_state = stm_pkg::S_EVAL;
                end
            end
            stm_pkg::S_EVAL: begin
                if (!match && keep) begin
                    we = 1'b1;
                end
                n_state = stm_pkg::S_READ;
            end
            stm_pkg::S_TAIL: begin
                if (r_cmd == stm_pkg::CMD_SWEEP
                    && r_b != stm_pkg::BW'(stm_pkg::BUCKETS - 1)) begin
                    n_state = stm_pkg::S_NEXTB;
                end else begin
                    n_state = stm_pkg::S_DONE;
                end
            end
            stm_pkg::S_DONE: begin
                if (o_res.ready) begin
                    n_state = stm_pkg::S_IDLE;
                end
            end
            default: n_state = stm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stm_pkg::S_IDLE;
            r_limit <= stm_pkg::AGE_LIMIT_RST;
            for (int k = 0; k < stm_pkg::BUCKETS; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (r_state)
                stm_pkg::S_NEXTB: begin
                    if (r_cmd == stm_pkg::CMD_INSERT
                        && fill_b < stm_pkg::FW'(stm_pkg::SLOTS_PER_BUCKET)) begin
                        r_fill[r_b] <= fill_b + 1'b1;
                    end
                end
                stm_pkg::S_TAIL: r_fill[r_b] <= r_wr;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            stm_pkg::S_IDLE: begin
                r_cmd <= i_req.command;
                r_b <= (i_req.command == stm_pkg::CMD_SWEEP) ? '0
                     : stm_pkg::BW'(i_req.bucket);
                r_user <= i_req.user_id;
                r_client <= i_req.client_id;
                r_sip <= i_req.server_ip;
                r_sport <= i_req.server_port;
                r_cip <= i_req.client_ip;
                r_cport <= i_req.client_port;
                r_rd <= '0;
                r_wr <= '0;
                r_hit <= 1'b0;
                r_status <= stm_pkg::ST_OK;
                r_fip <= '0;
                r_fport <= '0;
            end
            stm_pkg::S_NEXTB: begin
                r_rd <= '0;
                r_wr <= '0;
                if (r_cmd == stm_pkg::CMD_INSERT
                    && fill_b >= stm_pkg::FW'(stm_pkg::SLOTS_PER_BUCKET)) begin
                    r_status <= stm_pkg::ST_FULL;
                end
            end
            stm_pkg::S_EVAL: begin
                r_rd <= r_rd + 1'b1;
                if (match) begin
                    r_hit <= 1'b1;
                    r_fip <= rdata.client_ip;
                    r_fport <= rdata.client_port;
                end else if (keep) begin
                    r_wr <= r_wr + 1'b1;
                end
            end
            stm_pkg::S_TAIL: begin
                if (r_cmd == stm_pkg::CMD_LOOKUP && !r_hit) begin
                    r_status <= stm_pkg::ST_MISS;
                end
                if (r_cmd == stm_pkg::CMD_SWEEP) begin
                    r_b <= r_b + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> src/stm_slot_ram.sv
// Session slot memory, one write and one registered read port.
// Depends on stm_pkg.
`default_nettype none
module stm_slot_ram (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [stm_pkg::AW-1:0]     i_waddr,
    input  wire stm_pkg::t_slot       i_wdata,
    input  wire [stm_pkg::AW-1:0]     i_raddr,
    output stm_pkg::t_slot            o_rdata
);
    stm_pkg::t_slot mem [stm_pkg::DEPTH];
    stm_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> src/stm_checker.sv
// Port-level checker for the session table, bound to the top level.
// Depends on assert_macros.svh, stm_pkg and stm_if.
`default_nettype none
`include "assert_macros.svh"
module stm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    stm_req_if.sink   i_req,
    stm_res_if.source o_res
);
    `CHK_IMPLY(a_no_overlap, i_clk, i_rst_n, o_res.valid, !i_req.ready)
    `CHK_IMPLY(a_status_code, i_clk, i_rst_n, o_res.valid, o_res.status <= stm_pkg::ST_FULL)
    `CHK_IMPLY(a_zero_on_miss, i_clk, i_rst_n, o_res.valid && o_res.status != stm_pkg::ST_OK,
               o_res.found_client_ip == 32'd0 && o_res.found_client_port == 16'd0)
    `CHK_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req.valid && i_req.ready,
              !i_req.ready)
endmodule

bind session_table_match_and_age stm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .o_res(o_res)
);
`default_nettype wire
